// File: hw/rtl/slcd_pkg.sv
// Shared types, constants and a function for the sync/length/checksum deframer.
`timescale 1ns / 1ps
package slcd_pkg;

   localparam int unsigned LENGTH_WIDTH_DEFAULT = 16;
   localparam logic [7:0]  SYNC_FIRST           = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND          = 8'h55;
   localparam logic [15:0] SUM_ALL_ONES         = 16'hFFFF;
   localparam logic [15:0] MAX_PAYLOAD_RESET    = 16'd512;
   localparam logic        REG_MAX_PAYLOAD      = 1'b0;

   // controller -> datapath
   typedef struct packed {
      logic       hold_wr;     // write header hold entry
      logic [1:0] hold_idx;
      logic       sum_hi_wr;   // checksum high byte
      logic       sum_lo_wr;   // checksum low byte, length load, frame start
      logic       pay_step;    // payload byte
      logic       replay_sel;  // byte comes from header hold
      logic [1:0] replay_idx;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_sync1;
      logic is_sync2;
      logic check_fail;
      logic len_zero;
      logic pay_last;
   } dp_status_type;

   // 16-bit ones-complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

endpackage

// File: hw/rtl/slcd_ctrl.sv
// Deframer controller: hunt/header/payload sequencing and header replay.
`timescale 1ns / 1ps
module slcd_ctrl
   import slcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_take,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          replay_busy
);

   typedef enum logic [1:0] {
      PH_HUNT_A,
      PH_HUNT_B,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] index_ff, index_in;
   logic       replay_ff, replay_in;
   logic [1:0] rcnt_ff, rcnt_in;
   logic       step;
   logic [2:0] idx_minus2;

   assign step        = replay_ff | req_take;
   assign replay_busy = replay_ff;
   assign idx_minus2  = index_ff - 3'd2;

   always_comb begin
      phase_in       = phase_ff;
      index_in       = index_ff;
      replay_in      = replay_ff;
      rcnt_in        = rcnt_ff;
      cmd            = '0;
      cmd.replay_sel = replay_ff;
      cmd.replay_idx = rcnt_ff;
      cmd.hold_idx   = idx_minus2[1:0];

      if (replay_ff) begin
         rcnt_in = rcnt_ff + 2'd1;
         if (rcnt_ff == 2'd3) begin
            replay_in = 1'b0;
         end
      end

      if (step) begin
         case (phase_ff)
            PH_HUNT_A: begin
               phase_in = status.is_sync1 ? PH_HUNT_B : PH_HUNT_A;
            end
            PH_HUNT_B: begin
               phase_in = status.is_sync2 ? PH_HEADER : PH_HUNT_A;
               index_in = 3'd2;
            end
            PH_HEADER: begin
               if (index_ff < 3'd2) begin
                  phase_in = PH_HUNT_A;
                  index_in = 3'd0;
               end else begin
                  cmd.hold_wr = (index_ff <= 3'd5);
                  index_in    = index_ff + 3'd1;
                  if (index_ff == 3'd5 && status.check_fail) begin
                     // rescan length, version and check bytes from the hold
                     phase_in  = PH_HUNT_A;
                     index_in  = 3'd0;
                     replay_in = 1'b1;
                     rcnt_in   = 2'd0;
                  end
                  if (index_ff == 3'd6) begin
                     cmd.sum_hi_wr = 1'b1;
                  end
                  if (index_ff == 3'd7) begin
                     cmd.sum_lo_wr = 1'b1;
                     index_in      = 3'd0;
                     phase_in      = status.len_zero ? PH_HUNT_A : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               cmd.pay_step = 1'b1;
               if (status.pay_last) begin
                  phase_in = PH_HUNT_A;
               end
            end
            default: begin
               phase_in = PH_HUNT_A;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT_A;
         index_ff  <= 3'd0;
         replay_ff <= 1'b0;
         rcnt_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         index_ff  <= index_in;
         replay_ff <= replay_in;
         rcnt_ff   <= rcnt_in;
      end
   end

endmodule

// File: hw/rtl/slcd_datapath.sv
// Deframer datapath: header hold, length, checksum, payload count, output register.
`timescale 1ns / 1ps
module slcd_datapath
   import slcd_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    in_byte,
   input  logic [15:0]   max_payload,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_byte_valid,
   output logic          rsp_frame_end,
   output logic          rsp_checksum_ok,
   output logic [15:0]   rsp_frame_length
);

   localparam int unsigned PAD = 17 - LENGTH_WIDTH;

   logic [7:0]              hold_ff [4];
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;
   logic [15:0]             expect_ff, expect_in;
   logic [15:0]             count_ff, count_in;
   logic [15:0]             acc_ff, acc_in;
   logic [7:0]              hi_ff, hi_in;

   logic                    valid_ff, valid_in;
   logic [7:0]              obyte_ff, obyte_in;
   logic                    bvalid_ff, bvalid_in;
   logic                    fend_ff, fend_in;
   logic                    ok_ff, ok_in;
   logic [15:0]             flen_ff, flen_in;

   logic [7:0]              cur;
   logic [15:0]             raw_len;
   logic [LENGTH_WIDTH-1:0] new_len;
   logic [15:0]             new_expect;
   logic                    pay_valid;
   logic                    pay_last;
   logic [16:0]             pos_next;

   assign cur        = cmd.replay_sel ? hold_ff[cmd.replay_idx] : in_byte;
   assign raw_len    = {hold_ff[0], hold_ff[1]};
   assign new_len    = raw_len[LENGTH_WIDTH-1:0];
   assign new_expect = {expect_ff[15:8], cur};
   assign pos_next   = {1'b0, count_ff} + 17'd1;
   assign pay_valid  = count_ff < max_payload;
   assign pay_last   = pos_next >= {{PAD{1'b0}}, length_ff};

   assign status.is_sync1   = (cur == SYNC_FIRST);
   assign status.is_sync2   = (cur == SYNC_SECOND);
   assign status.check_fail = ((hold_ff[0] ^ hold_ff[1]) != cur);
   assign status.len_zero   = (new_len == '0);
   assign status.pay_last   = pay_last;

   always_comb begin
      length_in = length_ff;
      expect_in = expect_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      hi_in     = hi_ff;
      valid_in  = valid_ff & rsp_stall;
      obyte_in  = obyte_ff;
      bvalid_in = bvalid_ff;
      fend_in   = fend_ff;
      ok_in     = ok_ff;
      flen_in   = flen_ff;

      if (cmd.sum_hi_wr) begin
         expect_in = {cur, 8'd0};
      end
      if (cmd.sum_lo_wr) begin
         expect_in = new_expect;
         length_in = new_len;
         count_in  = 16'd0;
         acc_in    = 16'd0;
         hi_in     = 8'd0;
         if (status.len_zero) begin
            valid_in  = 1'b1;
            obyte_in  = 8'd0;
            bvalid_in = 1'b0;
            fend_in   = 1'b1;
            ok_in     = (new_expect == SUM_ALL_ONES);
            flen_in   = 16'(new_len);
         end
      end
      if (cmd.pay_step) begin
         if (!count_ff[0]) begin
            hi_in = cur;
            if (pay_last) begin
               acc_in = ones_add(acc_ff, {8'd0, cur});
            end
         end else begin
            acc_in = ones_add(acc_ff, {hi_ff, cur});
         end
         count_in = pos_next[15:0];
         if (pay_valid || pay_last) begin
            valid_in  = 1'b1;
            obyte_in  = pay_valid ? cur : 8'd0;
            bvalid_in = pay_valid;
            fend_in   = pay_last;
            ok_in     = pay_last && ((~acc_in) == expect_ff);
            flen_in   = 16'(length_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_wr) begin
         hold_ff[cmd.hold_idx] <= cur;
      end
      length_ff <= length_in;
      expect_ff <= expect_in;
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      hi_ff     <= hi_in;
      obyte_ff  <= obyte_in;
      bvalid_ff <= bvalid_in;
      fend_ff   <= fend_in;
      ok_ff     <= ok_in;
      flen_ff   <= flen_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = obyte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_checksum_ok  = ok_ff;
   assign rsp_frame_length = flen_ff;

endmodule

// File: hw/rtl/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum deframer with its register port.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_in_byte
//   rsp      out        rsp_valid/rsp_stall  out_byte, byte_valid, frame_end,
//                                            checksum_ok, frame_length
//   csr      in/out     APB-style            max_payload at byte address 0
//
// One request per cycle while req_stall is low; a request carrying a failed length
// check is followed by a replay of the four header hold bytes, with req_stall high.
// Results leave through a single output register; req_stall is high while it
// is full and rsp_stall holds it. Synchronous active-high reset returns to
// sync hunting with max_payload at 512.
`timescale 1ns / 1ps
module sync_length_checksum_deframer
   import slcd_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_end,
   output logic        rsp_checksum_ok,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          replay_busy;
   logic          req_take;
   logic [15:0]   max_payload_ff, max_payload_in;
   logic          csr_wr;

   assign req_stall = replay_busy | (rsp_valid & rsp_stall);
   assign req_take  = req_valid & ~req_stall;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign max_payload_in = (csr_wr && csr_paddr[2] == REG_MAX_PAYLOAD)
                           ? csr_pwdata[15:0] : max_payload_ff;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, max_payload_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   slcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_take    (req_take),
      .status      (status),
      .cmd         (cmd),
      .replay_busy (replay_busy)
   );

   slcd_datapath #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_byte          (req_in_byte),
      .max_payload      (max_payload_ff),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

// File: tb/sv/sync_length_checksum_deframer_tb.sv
// Self-checking testbench for the sync/length/checksum deframer: predictor, driver, monitor.
`timescale 1ns / 1ps
module sync_length_checksum_deframer_tb
   import slcd_pkg::*;
();

   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLDOFF_LEN  = 300;
   localparam int SETTLE_TICKS = 16;

   typedef enum logic [1:0] {HUNT_SYNC1, HUNT_SYNC2, IN_HEADER, IN_PAYLOAD} deframe_phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        frame_end;
      logic        checksum_ok;
      logic [15:0] frame_length;
   } deframe_result_type;

   // noise, doubled sync byte, empty frame, failed length check with rescan, one odd byte
   localparam logic [7:0] OPENING [23] = '{
      8'h00, 8'hFF,
      SYNC_FIRST, SYNC_FIRST,
      SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
      SYNC_FIRST, SYNC_SECOND, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h01,
      8'h5A, 8'h01, 8'hFF, 8'h7F, 8'h80
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_end;
   logic        rsp_checksum_ok;
   logic [15:0] rsp_frame_length;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [7:0]         byte_backlog [$];
   deframe_result_type predicted_results [$];

   // predictor state
   deframe_phase_type ph = HUNT_SYNC1;
   logic [7:0]        hdr_hold [4];
   logic [2:0]        hdr_idx = 3'd0;
   logic [15:0]       frame_len = 16'd0;
   logic [15:0]       hdr_sum = 16'd0;
   logic [15:0]       pay_count = 16'd0;
   logic [15:0]       run_sum = 16'd0;
   logic [7:0]        hi_hold = 8'd0;
   logic [15:0]       max_pay = MAX_PAYLOAD_RESET;

   int send_idle_pct = 0;
   int stall_pct = 0;
   bit holdoff_go = 1'b0;
   int holdoff_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int requests_taken = 0;
   int results_seen = 0;
   int frames_closed = 0;
   int settings_used = 0;

   sync_length_checksum_deframer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_frame_length(rsp_frame_length),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + 16'(s[16]);
   endfunction

   task automatic deframe_step(input logic [7:0] in_b, output bit produced,
                               output deframe_result_type res);
      logic [7:0]  work [$];
      logic [7:0]  b;
      logic [2:0]  idx;
      logic [15:0] pos;
      bit          pay_valid;
      bit          pay_last;
      produced = 1'b0;
      res = '0;
      if (ph == IN_PAYLOAD) begin
         pos = pay_count;
         pay_valid = pos < max_pay;
         pay_last = ({1'b0, pos} + 17'd1) >= {1'b0, frame_len};
         if (!pos[0]) begin
            hi_hold = in_b;
            if (pay_last) run_sum = ones_sum(run_sum, {8'h00, in_b});
         end else begin
            run_sum = ones_sum(run_sum, {hi_hold, in_b});
         end
         pay_count = pos + 16'd1;
         if (pay_last) ph = HUNT_SYNC1;
         if (pay_valid || pay_last) begin
            produced = 1'b1;
            res.out_byte = pay_valid ? in_b : 8'h00;
            res.byte_valid = pay_valid;
            res.frame_end = pay_last;
            res.checksum_ok = pay_last && ((~run_sum) == hdr_sum);
            res.frame_length = frame_len;
         end
      end else begin
         work.push_back(in_b);
         while (work.size() != 0) begin
            b = work.pop_front();
            case (ph)
               HUNT_SYNC2: begin
                  ph = (b == SYNC_SECOND) ? IN_HEADER : HUNT_SYNC1;
                  hdr_idx = 3'd2;
               end
               IN_HEADER: begin
                  idx = hdr_idx;
                  if (idx < 3'd2) begin
                     ph = HUNT_SYNC1;
                     hdr_idx = 3'd0;
                  end else begin
                     if (idx <= 3'd5) hdr_hold[2'(idx - 3'd2)] = b;
                     hdr_idx = idx + 3'd1;
                     if (idx == 3'd5 && (hdr_hold[0] ^ hdr_hold[1]) != hdr_hold[3]) begin
                        ph = HUNT_SYNC1;
                        hdr_idx = 3'd0;
                        for (int i = 0; i < 4; i++) work.push_back(hdr_hold[i]);
                     end else if (idx == 3'd6) begin
                        hdr_sum = {b, 8'h00};
                     end else if (idx == 3'd7) begin
                        hdr_sum[7:0] = b;
                        frame_len = 16'(((32'd1 << LENGTH_WIDTH_DEFAULT) - 32'd1)
                                        & {16'd0, hdr_hold[0], hdr_hold[1]});
                        pay_count = 16'd0;
                        run_sum = 16'd0;
                        hi_hold = 8'd0;
                        hdr_idx = 3'd0;
                        if (frame_len == 16'd0) begin
                           ph = HUNT_SYNC1;
                           produced = 1'b1;
                           res.frame_end = 1'b1;
                           res.checksum_ok = (hdr_sum == SUM_ALL_ONES);
                           res.frame_length = 16'd0;
                        end else begin
                           ph = IN_PAYLOAD;
                        end
                     end
                  end
               end
               default: begin
                  ph = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
               end
            endcase
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : driver
      bit                 produced;
      deframe_result_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_step(req_in_byte, produced, res);
            if (produced) predicted_results.push_back(res);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_in_byte <= byte_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      deframe_result_type want;
      if (holdoff_go) begin
         holdoff_left = HOLDOFF_LEN;
         holdoff_go = 1'b0;
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_results.size() == 0) begin
            $error("result with none predicted: out_byte %0h frame_end %0b",
                   rsp_out_byte, rsp_frame_end);
            mismatch_count++;
         end else begin
            want = predicted_results.pop_front();
            check_field("out_byte", 16'(want.out_byte), 16'(rsp_out_byte));
            check_field("byte_valid", 16'(want.byte_valid), 16'(rsp_byte_valid));
            check_field("frame_end", 16'(want.frame_end), 16'(rsp_frame_end));
            check_field("checksum_ok", 16'(want.checksum_ok), 16'(rsp_checksum_ok));
            check_field("frame_length", want.frame_length, rsp_frame_length);
         end
         results_seen++;
         if (rsp_frame_end) frames_closed++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
   endtask

   task automatic push_frame(input int len, input bit bad_sum);
      logic [7:0]  body [$];
      logic [15:0] acc;
      logic [15:0] sum_field;
      logic [15:0] flen;
      acc = 16'd0;
      flen = 16'(len);
      for (int i = 0; i < len; i++)
         body.push_back(($urandom_range(4) == 0) ? 8'hFF : 8'($urandom));
      for (int i = 1; i < len; i += 2) acc = ones_sum(acc, {body[i-1], body[i]});
      if (len % 2 == 1) acc = ones_sum(acc, {8'h00, body[len-1]});
      sum_field = ~acc;
      if (bad_sum) sum_field ^= 16'd1 << $urandom_range(15);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      push_byte(flen[15:8]);
      push_byte(flen[7:0]);
      push_byte(8'($urandom));
      push_byte(flen[15:8] ^ flen[7:0]);
      push_byte(sum_field[15:8]);
      push_byte(sum_field[7:0]);
      foreach (body[k]) push_byte(body[k]);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   task automatic write_max_payload(input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {REG_MAX_PAYLOAD, 2'b00};
      csr_pwdata <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      check_field("max_payload readback", value, csr_prdata[15:0]);
      check_field("csr_pready", 16'd1, 16'(csr_pready));
      max_pay = value;
      settings_used++;
   endtask

   task automatic random_traffic(input int budget);
      int         counted;
      int         r;
      int         len;
      logic [7:0] b;
      logic [7:0] hi;
      logic [7:0] lo;
      counted = 0;
      while (counted < budget) begin
         r = $urandom_range(99);
         if (r < 75) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            push_frame(len, $urandom_range(99) < 15);
            counted += len + 8;
         end else if (r < 83) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         end else if (r < 90) begin
            b = 8'($urandom);
            if (b == SYNC_SECOND) b = SYNC_FIRST;
            push_byte(SYNC_FIRST);
            push_byte(b);
            counted += 2;
         end else begin
            hi = 8'($urandom);
            lo = 8'($urandom);
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(hi);
            push_byte(lo);
            push_byte(8'($urandom));
            push_byte(hi ^ lo ^ 8'($urandom_range(1, 255)));
            counted += 6;
         end
         if ($urandom_range(39) == 0) wait_drained();
      end
   endtask

   task automatic run_phase(input logic [15:0] limit, input int idle, input int stall,
                            input int budget, input bit hold);
      wait_drained();
      repeat (SETTLE_TICKS) @(negedge clock);
      write_max_payload(limit);
      send_idle_pct = idle;
      stall_pct = stall;
      if (hold) holdoff_go = 1'b1;
      random_traffic(budget);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (OPENING[i]) push_byte(OPENING[i]);

      run_phase(MAX_PAYLOAD_RESET, 0, 0, 60, 1'b1);
      run_phase(16'd0, 67, 0, 60, 1'b0);
      run_phase(16'd3, 0, 67, 60, 1'b0);
      run_phase(16'hFFFF, 7, 7, 60, 1'b0);
      run_phase(16'($urandom_range(1, 20)), 67, 67, 60, 1'b0);
      wait_drained();
      repeat (SETTLE_TICKS) @(negedge clock);
      write_max_payload(MAX_PAYLOAD_RESET);
      send_idle_pct = 0;
      stall_pct = 0;
      push_frame(530, 1'b0);
      random_traffic(20);

      wait_drained();
      repeat (SETTLE_TICKS) @(negedge clock);
      $display("%0d requests in, %0d results checked, %0d frames closed",
               requests_taken, results_seen, frames_closed);
      $display("max_payload swept over %0d settings incl. 0 and 65535, under five idle mixes",
               settings_used);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
